FILE: hdl/lmcf_pkg.sv
package lmcf_pkg;

  localparam int CHAIN_LENGTH  = 8;
  localparam int PANEL_W       = 32;
  localparam int PANEL_H       = 16;
  localparam int REFRESH_WORDS = 8 * CHAIN_LENGTH;
  localparam int INIT_WORDS    = 5 * CHAIN_LENGTH;
  localparam int FB_DEPTH      = 64;

  typedef enum logic [1:0] {
    OP_PIXEL   = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_REFRESH = 2'd2,
    OP_INIT    = 2'd3
  } lmcf_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } lmcf_state_e;

  // Driver register addresses used by the setup sequence
  localparam logic [3:0] REG_TEST      = 4'h0F;
  localparam logic [3:0] REG_SHUTDOWN  = 4'h0C;
  localparam logic [3:0] REG_SCAN      = 4'h0B;
  localparam logic [3:0] REG_INTENSITY = 4'h0A;
  localparam logic [3:0] REG_DECODE    = 4'h09;

  typedef struct packed {
    lmcf_op_e   op;
    logic [5:0] idx;
    logic [2:0] bit_sel;
    logic       on;
  } lmcf_cmd_t;

  typedef struct packed {
    logic [3:0] reg_address;
    logic [7:0] reg_data;
    logic       frame_end;
    logic       last;
  } lmcf_word_t;

  function automatic logic [3:0] init_addr(logic [2:0] f);
    logic [3:0] a;
    case (f)
      3'd0:    a = REG_TEST;
      3'd1:    a = REG_SHUTDOWN;
      3'd2:    a = REG_SCAN;
      3'd3:    a = REG_INTENSITY;
      default: a = REG_DECODE;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] init_data(logic [2:0] f);
    logic [7:0] d;
    case (f)
      3'd1:    d = 8'h01;
      3'd2:    d = 8'h07;
      default: d = 8'h00;
    endcase
    return d;
  endfunction

endpackage

FILE: hdl/lmcf_fifo.sv
module lmcf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [LW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == LW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign level_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/lmcf_front.sv
module lmcf_front #(
  parameter int CMD_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [1:0]          command_i,
  input  logic [7:0]          pixel_x_i,
  input  logic [7:0]          pixel_y_i,
  input  logic                pixel_on_i,
  input  logic                cmd_pop_i,
  output logic                cmd_empty_o,
  output lmcf_pkg::lmcf_cmd_t cmd_o
);

  import lmcf_pkg::*;

  localparam int WidthCmd = $bits(lmcf_cmd_t);

  lmcf_cmd_t  dec;
  logic       in_range;
  logic       keep;
  logic [2:0] lx, ly;
  logic [1:0] blk;
  logic [WidthCmd-1:0] q_out;

  assign in_range = (pixel_x_i < 8'(PANEL_W)) && (pixel_y_i < 8'(PANEL_H));
  assign lx  = pixel_x_i[2:0];
  assign ly  = pixel_y_i[2:0];
  assign blk = pixel_x_i[4:3];

  // Map panel coordinates to driver row byte and bit
  always_comb begin
    dec.op = lmcf_op_e'(command_i);
    dec.on = pixel_on_i;
    if (!pixel_y_i[3]) begin
      dec.idx     = {1'b0, blk, ~ly};
      dec.bit_sel = lx;
    end else begin
      dec.idx     = {1'b1, ~blk, ly};
      dec.bit_sel = ~lx;
    end
  end

  // Drop out-of-range pixel writes here; they never reach the back end
  assign keep = (dec.op != OP_PIXEL) || in_range;

  lmcf_fifo #(
    .WIDTH (WidthCmd),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && keep),
    .data_i  (dec),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (q_out),
    .empty_o (cmd_empty_o),
    .level_o ()
  );

  assign cmd_o = lmcf_cmd_t'(q_out);

endmodule

FILE: hdl/lmcf_back.sv
module lmcf_back #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [3:0]                          cfg_intensity_i,
  input  logic                                cmd_empty_i,
  input  lmcf_pkg::lmcf_cmd_t                 cmd_i,
  output logic                                cmd_pop_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]      out_level_i,
  output logic                                word_valid_o,
  output lmcf_pkg::lmcf_word_t                word_o
);

  import lmcf_pkg::*;

  localparam int LW = $clog2(OUT_DEPTH+1);

  lmcf_state_e state_q, state_d;
  logic        refresh_q, refresh_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [3:0]  intensity_q;

  logic [7:0]  fb_mem [FB_DEPTH];
  logic [FB_DEPTH-1:0] fb_vld_q;
  logic        fb_we, fb_clr;
  logic [5:0]  rd_idx;
  logic [7:0]  rd_data_q;
  logic        rd_vld_q;

  logic        issue, last_word;
  logic [2:0]  frame, lane;
  logic        fend;
  logic [3:0]  w_addr;
  logic [7:0]  w_data;

  logic        s_valid_q;
  logic        s_refresh_q;
  logic [3:0]  s_addr_q;
  logic [7:0]  s_data_q;
  logic        s_fend_q, s_last_q;

  assign frame  = cnt_q[5:3];
  assign lane   = cnt_q[2:0];
  assign fend   = (lane == 3'(CHAIN_LENGTH-1));
  // Word i of a frame carries the row of the driver furthest down the chain first
  assign rd_idx = {3'(CHAIN_LENGTH-1) - lane, frame};

  assign issue = (state_q == ST_RUN) &&
                 (({1'b0, out_level_i} + (LW+1)'(s_valid_q)) < (LW+1)'(OUT_DEPTH));

  always_comb begin
    if (refresh_q) begin
      last_word = (cnt_q == 6'(REFRESH_WORDS-1));
      w_addr    = {1'b0, frame} + 4'd1;
      w_data    = '0;
    end else begin
      last_word = (cnt_q == 6'(INIT_WORDS-1));
      w_addr    = init_addr(frame);
      w_data    = (w_addr == REG_INTENSITY) ? {4'd0, intensity_q} : init_data(frame);
    end
  end

  always_comb begin
    state_d   = state_q;
    refresh_d = refresh_q;
    cnt_d     = cnt_q;
    cmd_pop_o = 1'b0;
    fb_we     = 1'b0;
    fb_clr    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_PIXEL: fb_we  = 1'b1;
            OP_CLEAR: fb_clr = 1'b1;
            default: begin
              refresh_d = (cmd_i.op == OP_REFRESH);
              cnt_d     = '0;
              state_d   = ST_RUN;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
          if (last_word) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      refresh_q   <= 1'b0;
      cnt_q       <= '0;
      intensity_q <= 4'd2;
      s_valid_q   <= 1'b0;
      fb_vld_q    <= '0;
    end else begin
      state_q   <= state_d;
      refresh_q <= refresh_d;
      cnt_q     <= cnt_d;
      s_valid_q <= issue;
      if (cfg_we_i) begin
        intensity_q <= cfg_intensity_i;
      end
      if (fb_clr) begin
        fb_vld_q <= '0;
      end else if (fb_we) begin
        fb_vld_q[cmd_i.idx] <= 1'b1;
      end
    end
  end

  // Framebuffer: an entry that is not valid reads as zero
  always_ff @(posedge clk_i) begin
    if (fb_we) begin
      if (fb_vld_q[cmd_i.idx]) begin
        fb_mem[cmd_i.idx][cmd_i.bit_sel] <= cmd_i.on;
      end else begin
        fb_mem[cmd_i.idx] <= 8'({7'd0, cmd_i.on} << cmd_i.bit_sel);
      end
    end
    rd_data_q <= fb_mem[rd_idx];
    rd_vld_q  <= fb_vld_q[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s_refresh_q <= refresh_q;
      s_addr_q    <= w_addr;
      s_data_q    <= w_data;
      s_fend_q    <= fend;
      s_last_q    <= last_word;
    end
  end

  assign word_valid_o       = s_valid_q;
  assign word_o.reg_address = s_addr_q;
  assign word_o.reg_data    = s_refresh_q ? (rd_vld_q ? rd_data_q : 8'd0) : s_data_q;
  assign word_o.frame_end   = s_fend_q;
  assign word_o.last        = s_last_q;

endmodule

FILE: hdl/led_matrix_chain_framebuffer.sv
// Framebuffer and word sequencer for a 32x16 LED panel of eight chained 8x8
// matrix drivers. Commands enter through a small command queue; pixel writes
// and clears are handled by the idle back end, and pixel writes outside the
// panel are dropped on entry. A refresh emits 64 chained words (8 frames of 8)
// and an init emits 40 (5 frames of 8), at most one word per cycle, paced by
// room in the result queue; the first word passes the command queue, the
// sequencer state, the word stage registers and the result queue on its way
// to the result ports. Clear takes effect at once through per-row valid
// bits, so there is no clearing pass.
// Write the intensity register only while the block is idle.
module led_matrix_chain_framebuffer #(
  parameter int CMD_DEPTH = 2,
  parameter int OUT_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] command_i,
  input  logic [7:0] pixel_x_i,
  input  logic [7:0] pixel_y_i,
  input  logic       pixel_on_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_intensity_i,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] reg_address_o,
  output logic [7:0] reg_data_o,
  output logic       frame_end_o,
  output logic       last_o
);

  import lmcf_pkg::*;

  localparam int WidthWord = $bits(lmcf_word_t);

  lmcf_cmd_t  cmd;
  logic       cmd_empty, cmd_pop;
  lmcf_word_t word, out_word;
  logic       word_valid;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_level;
  logic [WidthWord-1:0] out_bits;

  assign cfg_ready_o = 1'b1;

  lmcf_front #(
    .CMD_DEPTH (CMD_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .command_i   (command_i),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .pixel_on_i  (pixel_on_i),
    .cmd_pop_i   (cmd_pop),
    .cmd_empty_o (cmd_empty),
    .cmd_o       (cmd)
  );

  lmcf_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_intensity_i (cfg_intensity_i),
    .cmd_empty_i     (cmd_empty),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .out_level_i     (out_level),
    .word_valid_o    (word_valid),
    .word_o          (word)
  );

  lmcf_fifo #(
    .WIDTH (WidthWord),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (word_valid),
    .data_i  (word),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (out_bits),
    .empty_o (empty),
    .level_o (out_level)
  );

  assign out_word      = lmcf_word_t'(out_bits);
  assign reg_address_o = out_word.reg_address;
  assign reg_data_o    = out_word.reg_data;
  assign frame_end_o   = out_word.frame_end;
  assign last_o        = out_word.last;

endmodule

FILE: tb/sv/panel_word_checker.sv
`timescale 1ns / 100ps

module panel_word_checker
  import lmcf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  logic       full,
  input  logic [1:0] command_i,
  input  logic [7:0] pixel_x_i,
  input  logic [7:0] pixel_y_i,
  input  logic       pixel_on_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [3:0] cfg_intensity_i,
  input  logic       empty,
  input  logic       pop,
  input  logic [3:0] reg_address_i,
  input  logic [7:0] reg_data_i,
  input  logic       frame_end_i,
  input  logic       last_i,
  output int         mismatches_o,
  output int         words_pending_o
);

  logic [7:0] panel_rows [FB_DEPTH];
  logic [3:0] brightness;
  lmcf_word_t expected_words [$];
  lmcf_word_t oldest;

  initial begin
    mismatches_o    = 0;
    words_pending_o = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches_o++;
  endtask

  task automatic predict_words(input logic [1:0] op, input logic [7:0] x,
                               input logic [7:0] y, input logic on);
    logic [2:0] drv;
    logic [2:0] row;
    logic [2:0] bit_pos;
    logic [3:0] addr;
    logic [7:0] data;
    lmcf_word_t w;
    case (op)
      OP_PIXEL: begin
        // drop writes that fall outside the panel
        if (x < PANEL_W && y < PANEL_H) begin
          if (y < 8) begin
            // top half: only the row coordinate is flipped
            drv     = {1'b0, x[4:3]};
            row     = 3'd7 - y[2:0];
            bit_pos = x[2:0];
          end else begin
            drv     = 3'd7 - {1'b0, x[4:3]};
            row     = y[2:0];
            bit_pos = 3'd7 - x[2:0];
          end
          panel_rows[{drv, row}][bit_pos] = on;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < FB_DEPTH; i++) panel_rows[i] = 8'h00;
      end
      OP_REFRESH: begin
        for (int f = 0; f < 8; f++) begin
          for (int d = 0; d < CHAIN_LENGTH; d++) begin
            // far end of the chain is shifted out first
            drv           = 3'(CHAIN_LENGTH - 1 - d);
            row           = 3'(f);
            w.reg_address = 4'(f + 1);
            w.reg_data    = panel_rows[{drv, row}];
            w.frame_end   = (d == CHAIN_LENGTH - 1);
            w.last        = (d == CHAIN_LENGTH - 1) && (f == 7);
            expected_words.push_back(w);
          end
        end
      end
      OP_INIT: begin
        for (int f = 0; f < 5; f++) begin
          case (f)
            0:       begin addr = REG_TEST;      data = 8'h00;              end
            1:       begin addr = REG_SHUTDOWN;  data = 8'h01;              end
            2:       begin addr = REG_SCAN;      data = 8'h07;              end
            3:       begin addr = REG_INTENSITY; data = {4'h0, brightness}; end
            default: begin addr = REG_DECODE;    data = 8'h00;              end
          endcase
          for (int d = 0; d < CHAIN_LENGTH; d++) begin
            w.reg_address = addr;
            w.reg_data    = data;
            w.frame_end   = (d == CHAIN_LENGTH - 1);
            w.last        = (d == CHAIN_LENGTH - 1) && (f == 4);
            expected_words.push_back(w);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FB_DEPTH; i++) panel_rows[i] = 8'h00;
      brightness = 4'd2;
      expected_words.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, address", int'(reg_address_i), 0);
        end else begin
          oldest = expected_words.pop_front();
          if (reg_address_i !== oldest.reg_address)
            report_mismatch("reg_address", int'(reg_address_i), int'(oldest.reg_address));
          if (reg_data_i !== oldest.reg_data)
            report_mismatch("reg_data", int'(reg_data_i), int'(oldest.reg_data));
          if (frame_end_i !== oldest.frame_end)
            report_mismatch("frame_end", int'(frame_end_i), int'(oldest.frame_end));
          if (last_i !== oldest.last)
            report_mismatch("last", int'(last_i), int'(oldest.last));
        end
      end
      if (push && !full) predict_words(command_i, pixel_x_i, pixel_y_i, pixel_on_i);
      if (cfg_valid_i && cfg_ready_i) brightness = cfg_intensity_i;
    end
    words_pending_o = expected_words.size();
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import lmcf_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       push            = 1'b0;
  logic       full;
  logic [1:0] command_i       = OP_PIXEL;
  logic [7:0] pixel_x_i       = 8'h00;
  logic [7:0] pixel_y_i       = 8'h00;
  logic       pixel_on_i      = 1'b0;
  logic       cfg_valid_i     = 1'b0;
  logic       cfg_ready_o;
  logic [3:0] cfg_intensity_i = 4'h0;
  logic       empty;
  logic       pop             = 1'b0;
  logic [3:0] reg_address_o;
  logic [7:0] reg_data_o;
  logic       frame_end_o;
  logic       last_o;

  int mismatches;
  int words_pending;
  int send_idle_pct = 0;
  int rcv_idle_pct  = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  int quiet_cycles  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  led_matrix_chain_framebuffer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .pixel_on_i     (pixel_on_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_intensity_i(cfg_intensity_i),
    .empty          (empty),
    .pop            (pop),
    .reg_address_o  (reg_address_o),
    .reg_data_o     (reg_data_o),
    .frame_end_o    (frame_end_o),
    .last_o         (last_o)
  );

  panel_word_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .pixel_on_i     (pixel_on_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_intensity_i(cfg_intensity_i),
    .empty          (empty),
    .pop            (pop),
    .reg_address_i  (reg_address_o),
    .reg_data_i     (reg_data_o),
    .frame_end_i    (frame_end_o),
    .last_i         (last_o),
    .mismatches_o   (mismatches),
    .words_pending_o(words_pending)
  );

  // Result side: random pops, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (holds_done != hold_requests) begin
        holds_done++;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        pop <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_command(input lmcf_op_e op, input int x, input int y, input bit on);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push       <= 1'b1;
    command_i  <= op;
    pixel_x_i  <= x[7:0];
    pixel_y_i  <= y[7:0];
    pixel_on_i <= on;
    // full is stable from the falling edge up to the next rising edge
    @(negedge clk_i);
    while (full) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_random;
    int pick;
    int x;
    int y;
    pick = $urandom_range(99);
    x = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(31);
    y = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(15);
    if (pick < 60)      send_command(OP_PIXEL, x, y, $urandom_range(99) < 70);
    else if (pick < 65) send_command(OP_CLEAR, x, y, 1'($urandom_range(1)));
    else if (pick < 88) send_command(OP_REFRESH, x, y, 1'($urandom_range(1)));
    else                send_command(OP_INIT, x, y, 1'($urandom_range(1)));
  endtask

  // Drain all expected words, then let queued pixel writes and clears retire
  task automatic settle;
    push <= 1'b0;
    @(negedge clk_i);
    while (words_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_intensity(input int level);
    cfg_valid_i     <= 1'b1;
    cfg_intensity_i <= level[3:0];
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int level,
                           input int items, input bit with_hold);
    write_intensity(level);
    send_idle_pct = tx_pct;
    rcv_idle_pct  = rx_pct;
    send_command(OP_INIT, 0, 0, 1'b0);
    if (with_hold) begin
      // keep offering refreshes while the result side holds off
      hold_requests++;
      repeat (10) send_command(OP_REFRESH, 0, 0, 1'b0);
    end
    repeat (items) send_random();
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // init with the reset brightness, then an all-dark refresh
    send_command(OP_INIT, 0, 0, 1'b0);
    send_command(OP_REFRESH, 255, 255, 1'b1);
    // panel corners and the seam between the two halves
    send_command(OP_PIXEL, 0, 0, 1'b1);
    send_command(OP_PIXEL, 31, 0, 1'b1);
    send_command(OP_PIXEL, 0, 15, 1'b1);
    send_command(OP_PIXEL, 31, 15, 1'b1);
    send_command(OP_PIXEL, 0, 7, 1'b1);
    send_command(OP_PIXEL, 31, 8, 1'b1);
    send_command(OP_PIXEL, 7, 3, 1'b1);
    send_command(OP_PIXEL, 8, 12, 1'b1);
    // writes off the panel must leave the framebuffer alone
    send_command(OP_PIXEL, 32, 0, 1'b1);
    send_command(OP_PIXEL, 0, 16, 1'b1);
    send_command(OP_PIXEL, 255, 255, 1'b1);
    send_command(OP_PIXEL, 200, 5, 1'b1);
    send_command(OP_REFRESH, 0, 0, 1'b0);
    send_command(OP_PIXEL, 0, 0, 1'b0);
    send_command(OP_REFRESH, 0, 0, 1'b0);
    // clear must reach the last column and the last row too
    send_command(OP_CLEAR, 255, 255, 1'b1);
    send_command(OP_REFRESH, 0, 0, 1'b0);
    settle();

    run_phase(35, 67, 0, 60, 1'b0);
    run_phase(67, 35, 15, 60, 1'b0);
    run_phase(0, 0, $urandom_range(14, 1), 60, 1'b1);

    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hdl/lmcf_pkg.sv
hdl/lmcf_fifo.sv
hdl/lmcf_front.sv
hdl/lmcf_back.sv
hdl/led_matrix_chain_framebuffer.sv
tb/sv/panel_word_checker.sv
tb/sv/tb.sv
